// ===== hdl/clamped_running_median_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Clamped running median filter: assertion macros
// Shared property forms for the checker of the filter's ports.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_RUNNING_MEDIAN_FILTER_DEFINES_SVH
`define CLAMPED_RUNNING_MEDIAN_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRMF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRMF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/crmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Clamped running median filter package
// Window size, reset values, controller types and the sample clamp function.
// ----------------------------------------------------------------------------
`default_nettype none

package crmf_pkg;

    // Default window size and clamp limit after reset.
    localparam int          WINDOW_DEF  = 5;
    localparam logic [14:0] CLAMP_RESET = 15'd1500;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } crmf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;
        logic scan;
        logic load;
    } crmf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } crmf_stat_t;

    // Clamp a signed sample to the range [-lim, +lim].
    function automatic logic signed [15:0] clamp_sample(
        input logic signed [15:0] s,
        input logic [14:0]        lim
    );
        logic signed [16:0] s_ext;
        logic signed [16:0] lim_pos;
        logic signed [16:0] lim_neg;
        logic signed [16:0] res;
        s_ext   = {s[15], s};
        lim_pos = {2'b00, lim};
        lim_neg = -lim_pos;
        if (s_ext > lim_pos)
            res = lim_pos;
        else if (s_ext < lim_neg)
            res = lim_neg;
        else
            res = s_ext;
        return res[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Clamped running median filter controller
// Sequences window write, rank scan and output load; owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module crmf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output crmf_pkg::crmf_cmd_t       cmd,
    input  wire crmf_pkg::crmf_stat_t stat
);

    crmf_pkg::crmf_state_t state_reg;
    crmf_pkg::crmf_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crmf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            crmf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.write  = 1'b1;
                    state_next = crmf_pkg::ST_SCAN;
                end
            end
            crmf_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                    state_next = crmf_pkg::ST_FINISH;
            end
            crmf_pkg::ST_FINISH:
            begin
                // Load only when the output register is empty or being emptied.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = crmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crmf_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/crmf_dp.sv =====
// ----------------------------------------------------------------------------
// Clamped running median filter datapath
// Clamp register, two sample windows, a rank-compare scan unit per axis
// and the output data register.
// ----------------------------------------------------------------------------
`default_nettype none

module crmf_dp #(
    parameter int WINDOW = crmf_pkg::WINDOW_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [14:0]          cfg_wdata,
    input  wire logic [31:0]          s_tdata,
    input  wire crmf_pkg::crmf_cmd_t  cmd,
    output crmf_pkg::crmf_stat_t      stat,
    output logic [31:0]               m_tdata
);

    localparam int                IDX_W    = $clog2(WINDOW);
    localparam logic [IDX_W-1:0]  MID_IDX  = IDX_W'(WINDOW >> 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW - 1);

    logic [14:0]        clamp_reg;
    logic signed [15:0] win_x_reg [WINDOW];
    logic signed [15:0] win_y_reg [WINDOW];
    logic [IDX_W-1:0]   wpos_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic signed [15:0] med_x_reg;
    logic signed [15:0] med_y_reg;
    logic [31:0]        out_data_reg;

    logic signed [15:0] samp_x;
    logic signed [15:0] samp_y;
    logic signed [15:0] cand_x;
    logic signed [15:0] cand_y;
    logic [IDX_W-1:0]   rank_x;
    logic [IDX_W-1:0]   rank_y;

    // Clamped samples of the incoming item.
    assign samp_x = crmf_pkg::clamp_sample(s_tdata[15:0], clamp_reg);
    assign samp_y = crmf_pkg::clamp_sample(s_tdata[31:16], clamp_reg);

    // Stable rank of the candidate: smaller entries, plus equal entries
    // at lower positions. Exactly one entry has the middle rank.
    always_comb
    begin
        cand_x = win_x_reg[cnt_reg];
        cand_y = win_y_reg[cnt_reg];
        rank_x = '0;
        rank_y = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if ((win_x_reg[j] < cand_x) ||
                ((win_x_reg[j] == cand_x) && (IDX_W'(j) < cnt_reg)))
                rank_x = rank_x + 1'b1;
            if ((win_y_reg[j] < cand_y) ||
                ((win_y_reg[j] == cand_y) && (IDX_W'(j) < cnt_reg)))
                rank_y = rank_y + 1'b1;
        end
    end

    assign stat.scan_last = (cnt_reg == LAST_IDX);

    // Clamp limit, windows, write position and scan counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg <= crmf_pkg::CLAMP_RESET;
            wpos_reg  <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wen)
                clamp_reg <= cfg_wdata;
            if (cmd.write)
            begin
                win_x_reg[wpos_reg] <= samp_x;
                win_y_reg[wpos_reg] <= samp_y;
                wpos_reg <= (wpos_reg == LAST_IDX) ? '0 : wpos_reg + 1'b1;
                cnt_reg  <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // Median capture during the scan and the output data register.
    always_ff @(posedge clk)
    begin
        if (cmd.scan && (rank_x == MID_IDX))
            med_x_reg <= cand_x;
        if (cmd.scan && (rank_y == MID_IDX))
            med_y_reg <= cand_y;
        if (cmd.load)
            out_data_reg <= {med_y_reg, med_x_reg};
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/clamped_running_median_filter.sv =====
// ----------------------------------------------------------------------------
// Clamped running median filter
// Clamps X and Y velocity samples, keeps a circular window per axis and
// returns the median of each window for every input item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload (low bits first)          Handshake
//  s_*       in         vel_x_sample, vel_y_sample        tvalid/tready
//  m_*       out        median_x, median_y                tvalid/tready
//  cfg_*     in         clamp_limit                       cfg_wen strobe
//
//  An accepted item is written into both windows, then each window entry
//  is rank-scanned in turn in the per-axis compare units, then the result
//  is loaded into the output register.
//  The next item is accepted as soon as the result is loaded, even while
//  it still waits at the output; a stalled output holds the scan at its end.
//  Reset clears both windows to zero, the write position, and sets the
//  clamp limit to 1500.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_running_median_filter #(
    parameter int WINDOW = crmf_pkg::WINDOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [14:0] cfg_wdata,    // clamp_limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,      // [15:0] vel_x_sample, [31:16] vel_y_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata       // [15:0] median_x, [31:16] median_y
);

    crmf_pkg::crmf_cmd_t  cmd;
    crmf_pkg::crmf_stat_t stat;

    // Sequencing.
    crmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Windows and median search.
    crmf_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/crmf_checker.sv =====
// ----------------------------------------------------------------------------
// Clamped running median filter port checker
// Watches the top level's ports for output stability and result bounds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clamped_running_median_filter_defines.svh"

module crmf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result stays offered.
    `CRMF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A stalled result keeps its value.
    `CRMF_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // The window scan follows every accepted item, so input is closed next cycle.
    `CRMF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken during scan")

    // Clamped values never reach the most negative code.
    `CRMF_ASSERT_SAME(a_median_range, clk, rst_n, m_tvalid, (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000), "median outside clamp range")

endmodule

bind clamped_running_median_filter crmf_checker u_crmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
